>>> hdl/multichannel_manchester_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder modules.
`ifndef MULTICHANNEL_MANCHESTER_FRAME_DECODER_MACROS_SVH
`define MULTICHANNEL_MANCHESTER_FRAME_DECODER_MACROS_SVH

// Checks a condition at every clock edge outside of reset.
`define MFD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a trigger is followed by a consequence in the following cycle.
`define MFD_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mfd_pkg.sv
// Shared types and constants of the Manchester frame decoder.
package mfd_pkg;

	localparam int PIN_W = 12;
	localparam int DATA_W = 16;
	localparam int SRC_W = 4;
	localparam int LANE_MAX = 16;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_CHECK  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [DATA_W-1:0] frame_data;
		logic [SRC_W-1:0]  source_sensor;
		logic [PIN_W-1:0]  receiving_mask;
	} result_t;

endpackage

>>> hdl/mfd_front.sv
// Input side of the decoder: accepts pin samples into a two-entry queue.
`include "multichannel_manchester_frame_decoder_macros.svh"

module mfd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mfd_pkg::PIN_W-1:0] sample_pins,
	output logic                      q_valid,
	input  logic                      q_ready,
	output logic [mfd_pkg::PIN_W-1:0] q_pins
);

	logic [mfd_pkg::PIN_W-1:0] mem_q [2];
	logic                      wr_ptr_q;
	logic                      rd_ptr_q;
	logic [1:0]                cnt_q;
	logic                      push;
	logic                      pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_pins   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= sample_pins;
		end
	end

	`MFD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 2'd2, "queue count overflow")
	`MFD_ASSERT_NEXT(a_push_visible, push && cnt_q == 2'd0, q_valid, "pushed beat not visible")

endmodule

>>> hdl/mfd_back.sv
// Lane array: per-sensor Manchester decoding, shared phase and result register.
`include "multichannel_manchester_frame_decoder_macros.svh"

module mfd_back #(
	parameter int SENSORS    = 12,
	parameter int HEADER_LEN = 6,
	parameter int DATA_LEN   = 16,
	parameter int CHECK_LEN  = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      compute_on_board,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  logic [mfd_pkg::PIN_W-1:0] q_pins,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mfd_pkg::result_t          result
);

	localparam int CW = $clog2(SENSORS + 1);
	localparam logic [mfd_pkg::DATA_W-1:0] DMASK =
		mfd_pkg::DATA_W'((32'd1 << DATA_LEN) - 32'd1);

	mfd_pkg::phase_t           ph_q, ph_nx;
	logic [CW-1:0]             dc_q;
	logic [SENSORS-1:0]        en_q, en_d;
	logic [SENSORS-1:0]        fok_q, fok_d;
	logic [2:0]                hc_q [SENSORS];
	logic [2:0]                hc_d [SENSORS];
	logic                      fh_q [SENSORS];
	logic                      fh_d [SENSORS];
	logic [4:0]                bl_q [SENSORS];
	logic [4:0]                bl_d [SENSORS];
	logic [mfd_pkg::DATA_W-1:0] da_q [SENSORS];
	logic [mfd_pkg::DATA_W-1:0] da_d [SENSORS];
	logic [3:0]                oc_q [SENSORS];
	logic [3:0]                oc_d [SENSORS];
	logic [3:0]                ca_q [SENSORS];
	logic [3:0]                ca_d [SENSORS];
	logic [mfd_pkg::LANE_MAX-1:0] pins_ext;
	logic [CW-1:0]             n_dis;
	logic [CW:0]               dc_sum;
	logic                      all_off;
	logic                      any_pass;
	logic                      got;
	logic                      step;
	logic [mfd_pkg::DATA_W-1:0] win_data;
	logic [mfd_pkg::SRC_W-1:0] win_src;
	logic [mfd_pkg::PIN_W-1:0] mask;
	logic                      out_valid_q;
	mfd_pkg::result_t          res_q;

	assign pins_ext  = mfd_pkg::LANE_MAX'(q_pins);
	assign q_ready   = !out_valid_q || out_ready;
	assign step      = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	always_comb begin
		logic b;
		logic dis;
		logic acc;
		logic [4:0] sh;
		ph_nx    = ph_q;
		n_dis    = '0;
		any_pass = 1'b0;
		win_data = '0;
		win_src  = '0;
		en_d     = en_q;
		fok_d    = fok_q;
		for (int i = 0; i < SENSORS; i++) begin
			hc_d[i] = hc_q[i];
			fh_d[i] = fh_q[i];
			bl_d[i] = bl_q[i];
			da_d[i] = da_q[i];
			oc_d[i] = oc_q[i];
			ca_d[i] = ca_q[i];
			b   = pins_ext[i];
			dis = 1'b0;
			acc = 1'b0;
			sh  = '0;
			if (en_q[i]) begin
				case (ph_q)
					mfd_pkg::PH_HEADER: begin
						if (!b) begin
							hc_d[i] = hc_q[i] + 3'd1;
						end else begin
							dis     = 1'b1;
							hc_d[i] = 3'd0;
						end
						if (hc_d[i] == 3'(HEADER_LEN)) begin
							ph_nx   = mfd_pkg::PH_DATA;
							hc_d[i] = 3'd0;
							bl_d[i] = 5'(DATA_LEN);
							da_d[i] = '0;
							oc_d[i] = 4'd0;
						end
					end
					mfd_pkg::PH_DATA, mfd_pkg::PH_CHECK: begin
						// The first half-bit is stored, the second must differ from it.
						if (hc_q[i] == 3'd0) begin
							hc_d[i] = 3'd1;
							fh_d[i] = b;
						end else begin
							hc_d[i] = 3'd0;
							if (b != fh_q[i]) begin
								acc = 1'b1;
							end else begin
								dis = 1'b1;
							end
						end
						if (ph_q == mfd_pkg::PH_DATA) begin
							if (acc) begin
								sh      = 5'(DATA_LEN) - bl_q[i];
								da_d[i] = (da_q[i] + (mfd_pkg::DATA_W'(b) << sh)) & DMASK;
								bl_d[i] = bl_q[i] - 5'd1;
								if (!fh_q[i]) begin
									oc_d[i] = oc_q[i] + 4'd1;
								end
							end
							if (bl_d[i] == 5'd0) begin
								ph_nx   = mfd_pkg::PH_CHECK;
								bl_d[i] = 5'(CHECK_LEN);
								hc_d[i] = 3'd0;
								ca_d[i] = 4'd0;
							end
						end else begin
							if (acc) begin
								sh      = bl_q[i] - 5'd1;
								ca_d[i] = ca_q[i] + (4'(b) << sh);
								bl_d[i] = bl_q[i] - 5'd1;
							end
							if (bl_d[i] == 5'd0) begin
								if (4'(ca_d[i] + oc_q[i]) == 4'd0) begin
									fok_d[i] = 1'b1;
									any_pass = 1'b1;
									win_data = da_d[i];
									win_src  = mfd_pkg::SRC_W'(i);
								end
								hc_d[i] = 3'd0;
								bl_d[i] = 5'(DATA_LEN);
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (dis) begin
				en_d[i] = 1'b0;
				n_dis   = n_dis + CW'(1);
			end
		end
		dc_sum  = (CW+1)'(dc_q) + (CW+1)'(n_dis);
		all_off = (dc_sum == (CW+1)'(SENSORS));
		got     = any_pass && !all_off;
		mask    = '0;
		for (int i = 0; i < SENSORS; i++) begin
			if (i < mfd_pkg::PIN_W) begin
				mask[i] = fok_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= mfd_pkg::PH_HEADER;
			dc_q        <= '0;
			en_q        <= '1;
			fok_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SENSORS; i++) begin
				hc_q[i] <= 3'd0;
				fh_q[i] <= 1'b0;
				bl_q[i] <= 5'd0;
				da_q[i] <= '0;
				oc_q[i] <= 4'd0;
				ca_q[i] <= 4'd0;
			end
		end else begin
			if (step && got) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (step) begin
				for (int i = 0; i < SENSORS; i++) begin
					hc_q[i] <= hc_d[i];
					fh_q[i] <= fh_d[i];
					bl_q[i] <= bl_d[i];
					da_q[i] <= da_d[i];
					oc_q[i] <= oc_d[i];
					ca_q[i] <= ca_d[i];
				end
				// Every lane dropped out, or a good frame with on-board compute: re-arm.
				if (all_off || (got && compute_on_board)) begin
					en_q <= '1;
					ph_q <= mfd_pkg::PH_HEADER;
					dc_q <= '0;
				end else begin
					en_q <= en_d;
					ph_q <= ph_nx;
					dc_q <= dc_sum[CW-1:0];
				end
				fok_q <= (got && compute_on_board) ? '0 : fok_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && got) begin
			res_q.frame_data     <= win_data;
			res_q.source_sensor  <= win_src;
			res_q.receiving_mask <= mask;
		end
	end

	`MFD_ASSERT_ALWAYS(a_dc_bound, dc_q < CW'(SENSORS), "disable count reached lane count")
	`MFD_ASSERT_NEXT(a_rearm, step && all_off, ph_q == mfd_pkg::PH_HEADER && en_q == '1, "no re-arm")
	`MFD_ASSERT_NEXT(a_hold, !step, $stable(ph_q) && $stable(en_q), "lane state moved without a beat")

endmodule

>>> hdl/multichannel_manchester_frame_decoder.sv
// Twelve-lane Manchester frame decoder with a shared header, data and check phase.
// Each accepted pin sample advances every lane, so the block takes one sample per clock
// unless the output stalls; that figure is set by the lane array, which updates all
// lanes together, and a result leaves through a registered output in the cycle after
// its sample enters the lanes. A two-entry queue parts input from the lane array, and
// an output register parts the lane array from the result side. The configuration
// port is always ready and should be written only while the block is idle.
`include "multichannel_manchester_frame_decoder_macros.svh"

module multichannel_manchester_frame_decoder #(
	parameter int SENSORS    = 12,
	parameter int HEADER_LEN = 6,
	parameter int DATA_LEN   = 16,
	parameter int CHECK_LEN  = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mfd_pkg::PIN_W-1:0]  sample_pins,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mfd_pkg::DATA_W-1:0] frame_data,
	output logic [mfd_pkg::SRC_W-1:0]  source_sensor,
	output logic [mfd_pkg::PIN_W-1:0]  receiving_mask
);

	logic                      cob_q;
	logic                      q_valid;
	logic                      q_ready;
	logic [mfd_pkg::PIN_W-1:0] q_pins;
	mfd_pkg::result_t          result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cob_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			cob_q <= cfg_data;
		end
	end

	mfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_pins (sample_pins),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_pins      (q_pins)
	);

	mfd_back #(
		.SENSORS    (SENSORS),
		.HEADER_LEN (HEADER_LEN),
		.DATA_LEN   (DATA_LEN),
		.CHECK_LEN  (CHECK_LEN)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.compute_on_board (cob_q),
		.q_valid          (q_valid),
		.q_ready          (q_ready),
		.q_pins           (q_pins),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result           (result)
	);

	assign frame_data     = result.frame_data;
	assign source_sensor  = result.source_sensor;
	assign receiving_mask = result.receiving_mask;

endmodule
